### rtl/bqif_pkg.sv
// Shared types, constants and helpers for the biquad IIR filter core.
package bqif_pkg;

  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_WIDTH     = 25;
  localparam int COEF_FRAC_BITS = 22;
  localparam int GAIN_WIDTH     = 24;
  localparam int GAIN_FRAC_BITS = 20;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 5;
  localparam int REG_IDX_WIDTH  = 3;

  // one shared multiplier: coefficient (or zero-extended gain) times sample
  localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
  // five products summed: three guard bits
  localparam int ACC_WIDTH  = PROD_WIDTH + 3;

  localparam logic signed [ACC_WIDTH-1:0] ACC_HALF =
    {{(ACC_WIDTH-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_WIDTH-1:0] GAIN_HALF =
    {{(ACC_WIDTH-1){1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);
  localparam logic signed [ACC_WIDTH-1:0] SAMPLE_MAX =
    {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] SAMPLE_MIN =
    {{(ACC_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  // register indexes on the config port
  localparam logic [REG_IDX_WIDTH-1:0] REG_FF0  = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FF1  = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FF2  = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FB1  = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FB2  = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_GAIN = 3'd5;

  localparam logic signed [COEF_WIDTH-1:0] FF0_RESET  = 25'sd4194304;
  localparam logic [GAIN_WIDTH-1:0]        GAIN_RESET = 24'd1048576;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] ff0;
    logic signed [COEF_WIDTH-1:0] ff1;
    logic signed [COEF_WIDTH-1:0] ff2;
    logic signed [COEF_WIDTH-1:0] fb1;
    logic signed [COEF_WIDTH-1:0] fb2;
    logic [GAIN_WIDTH-1:0]        gain;
  } cfg_t;

  typedef enum logic [2:0] {
    TAP_FF0  = 3'd0,
    TAP_FF1  = 3'd1,
    TAP_FF2  = 3'd2,
    TAP_FB1  = 3'd3,
    TAP_FB2  = 3'd4,
    TAP_GAIN = 3'd5
  } tap_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_UPDATE,
    ST_GAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_x;
    logic mul_en;
    tap_t tap;
    logic acc_clr;
    logic acc_en;
    logic update;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [ACC_WIDTH-1:0] v
  );
    logic signed [ACC_WIDTH-1:0] c;
    if (v > SAMPLE_MAX) begin
      c = SAMPLE_MAX;
    end else if (v < SAMPLE_MIN) begin
      c = SAMPLE_MIN;
    end else begin
      c = v;
    end
    return c[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

### rtl/biquad_iir_filter_core.sv
// Top level of the biquad IIR filter core (direct form I).
//
// Usage:
//  - s_axis: one signed 24-bit sample per word. m_axis: one filtered,
//    gain-scaled, saturated 24-bit sample per input word, in order.
//  - APB port: six registers at byte offsets 0x00..0x14 (ff0, ff1, ff2,
//    fb1, fb2 in Q3.22, gain in unsigned Q4.20). Write only while idle.
//  - One multiplier is shared over the five taps and the gain, so a sample
//    passes these steps before the next one is taken: 1 accept, 5 tap
//    multiplies, 1 final accumulate, 1 round/saturate and delay update,
//    1 gain multiply, 1 output load.
//  - The output register holds a finished word while m_axis stalls; the
//    core stays in its output step until that register can be loaded, and
//    takes no new sample meanwhile.
//  - Reset (rst, synchronous) clears the delay line, drops m_axis_tvalid
//    and sets ff0 = 1.0, gain = 1.0, the other coefficients to zero.
module biquad_iir_filter_core (
  input  logic                                     clk,
  input  logic                                     rst,
  // s_axis_tdata: [23:0] sample_in
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic signed [bqif_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,
  // m_axis_tdata: [23:0] sample_out
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic signed [bqif_pkg::SAMPLE_WIDTH-1:0] m_axis_tdata,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [bqif_pkg::APB_ADDR_WIDTH-1:0]      paddr,
  input  logic [bqif_pkg::APB_DATA_WIDTH-1:0]      pwdata,
  output logic [bqif_pkg::APB_DATA_WIDTH-1:0]      prdata,
  output logic                                     pready
);
  import bqif_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bqif_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: accepts a word only in its idle step
  bqif_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bqif_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .stat    (stat),
    .x_in    (s_axis_tdata),
    .y_out   (m_axis_tdata),
    .y_valid (m_axis_tvalid),
    .y_ready (m_axis_tready)
  );

endmodule

### rtl/bqif_regs.sv
// Configuration register file with APB-style access.
module bqif_regs (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [bqif_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  logic [bqif_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic [bqif_pkg::APB_DATA_WIDTH-1:0]     prdata,
  output logic                                    pready,
  output bqif_pkg::cfg_t                          cfg
);
  import bqif_pkg::*;

  logic [REG_IDX_WIDTH-1:0] idx;
  logic                     wr;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_WIDTH-1:2];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ff0  <= FF0_RESET;
      cfg.ff1  <= '0;
      cfg.ff2  <= '0;
      cfg.fb1  <= '0;
      cfg.fb2  <= '0;
      cfg.gain <= GAIN_RESET;
    end else if (wr) begin
      case (idx)
        REG_FF0:  cfg.ff0  <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_FF1:  cfg.ff1  <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_FF2:  cfg.ff2  <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_FB1:  cfg.fb1  <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_FB2:  cfg.fb2  <= $signed(pwdata[COEF_WIDTH-1:0]);
        REG_GAIN: cfg.gain <= pwdata[GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FF0:  prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg.ff0};
      REG_FF1:  prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg.ff1};
      REG_FF2:  prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg.ff2};
      REG_FB1:  prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg.fb1};
      REG_FB2:  prdata = {{(APB_DATA_WIDTH-COEF_WIDTH){1'b0}}, cfg.fb2};
      REG_GAIN: prdata = {{(APB_DATA_WIDTH-GAIN_WIDTH){1'b0}}, cfg.gain};
      default:  prdata = '0;
    endcase
  end

endmodule

### rtl/bqif_ctrl.sv
// Sequencer for the biquad: steps the shared multiply-accumulate per sample.
module bqif_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bqif_pkg::dp_stat_t  stat,
  output bqif_pkg::dp_cmd_t   cmd
);
  import bqif_pkg::*;

  state_t state, state_next;
  tap_t   tap, tap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= TAP_FF0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    tap_next   = tap;
    case (state)
      ST_IDLE: begin
        tap_next = TAP_FF0;
        if (in_valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        tap_next = tap_t'(tap + 3'd1);
        if (tap == TAP_FB2) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_OUT;
      ST_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs; no word is taken while reset is held
  always_comb begin
    cmd      = '0;
    cmd.tap  = tap;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = !rst;
        cmd.load_x = in_valid & !rst;
      end
      ST_MAC: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_clr = (tap == TAP_FF0);
        cmd.acc_en  = (tap != TAP_FF0);
      end
      ST_DRAIN:  cmd.acc_en = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_GAIN: begin
        cmd.mul_en = 1'b1;
        cmd.tap    = TAP_GAIN;
      end
      ST_OUT:    cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/bqif_datapath.sv
// Biquad datapath: delay line, shared multiplier, accumulator, round and saturate.
module bqif_datapath (
  input  logic                                       clk,
  input  logic                                       rst,
  input  bqif_pkg::cfg_t                             cfg,
  input  bqif_pkg::dp_cmd_t                          cmd,
  output bqif_pkg::dp_stat_t                         stat,
  input  logic signed [bqif_pkg::SAMPLE_WIDTH-1:0]   x_in,
  output logic signed [bqif_pkg::SAMPLE_WIDTH-1:0]   y_out,
  output logic                                       y_valid,
  input  logic                                       y_ready
);
  import bqif_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] x, in_d1, in_d2, out_d1, out_d2;
  logic signed [COEF_WIDTH-1:0]   coef_op;
  logic signed [SAMPLE_WIDTH-1:0] samp_op;
  logic signed [PROD_WIDTH-1:0]   prod;
  logic                           prod_sub;
  logic signed [ACC_WIDTH-1:0]    acc, prod_ext;
  logic signed [ACC_WIDTH-1:0]    acc_sum, acc_rnd, gain_sum, gain_rnd;
  logic signed [SAMPLE_WIDTH-1:0] y_sat, r_sat;

  always_comb begin
    case (cmd.tap)
      TAP_FF0:  begin coef_op = cfg.ff0; samp_op = x;      end
      TAP_FF1:  begin coef_op = cfg.ff1; samp_op = in_d1;  end
      TAP_FF2:  begin coef_op = cfg.ff2; samp_op = in_d2;  end
      TAP_FB1:  begin coef_op = cfg.fb1; samp_op = out_d1; end
      TAP_FB2:  begin coef_op = cfg.fb2; samp_op = out_d2; end
      TAP_GAIN: begin
        coef_op = $signed({{(COEF_WIDTH-GAIN_WIDTH){1'b0}}, cfg.gain});
        samp_op = out_d1;
      end
      default:  begin coef_op = '0; samp_op = '0; end
    endcase
  end

  assign prod_ext = {{(ACC_WIDTH-PROD_WIDTH){prod[PROD_WIDTH-1]}}, prod};

  always_comb begin
    acc_sum  = acc + ACC_HALF;
    acc_rnd  = acc_sum >>> COEF_FRAC_BITS;
    y_sat    = sat_sample(acc_rnd);
    gain_sum = prod_ext + GAIN_HALF;
    gain_rnd = gain_sum >>> GAIN_FRAC_BITS;
    r_sat    = sat_sample(gain_rnd);
  end

  // sample load, multiplier stage, accumulate, then output load
  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= x_in;
    end
    if (cmd.mul_en) begin
      prod     <= coef_op * samp_op;
      prod_sub <= (cmd.tap == TAP_FB1) || (cmd.tap == TAP_FB2);
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= prod_sub ? acc - prod_ext : acc + prod_ext;
    end
    if (cmd.out_load) begin
      y_out <= r_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_d1  <= '0;
      in_d2  <= '0;
      out_d1 <= '0;
      out_d2 <= '0;
    end else if (cmd.update) begin
      in_d2  <= in_d1;
      in_d1  <= x;
      out_d2 <= out_d1;
      out_d1 <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else if (cmd.out_load) begin
      y_valid <= 1'b1;
    end else if (y_ready) begin
      y_valid <= 1'b0;
    end
  end

  assign stat.out_free = !y_valid || y_ready;

endmodule

### dv/biquad_iir_filter_core_tb.sv
// Self-checking testbench for the biquad IIR filter core: directed table, then random phases.
`timescale 1ns / 100ps

module biquad_iir_filter_core_tb;
  import bqif_pkg::*;

  // Cycles with no word moving on either stream before the run is called hung.
  // Slowest correct gap is a sender gap, one sample's processing, a long receiver
  // stall, or a drain plus seven config writes; this is many times that.
  localparam int IDLE_LIMIT    = 3000;
  // Wait after the last output comes back, to let the core settle.
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 12;
  localparam int PHASE_WORDS   = 111;

  // Decoded holes in the register map: writes there must change nothing.
  localparam logic [REG_IDX_WIDTH-1:0] REG_HOLE6 = 3'd6;
  localparam logic [REG_IDX_WIDTH-1:0] REG_HOLE7 = 3'd7;

  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = 24'sh800000;
  localparam logic signed [COEF_WIDTH-1:0]   C_MAX = 25'sh0FFFFFF;
  localparam logic signed [COEF_WIDTH-1:0]   C_MIN = 25'sh1000000;
  localparam logic [GAIN_WIDTH-1:0]          G_MAX = 24'hFFFFFF;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  // One row of the directed table: either a register write or a sample word,
  // the latter with an optional hand-typed expected output.
  typedef struct packed {
    row_kind_e                      kind;
    logic [REG_IDX_WIDTH-1:0]       reg_idx;
    logic [APB_DATA_WIDTH-1:0]      wdata;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    bit                             has_want;
    logic signed [SAMPLE_WIDTH-1:0] want;
  } stim_row_t;

  logic                             clk;
  logic                             rst;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic signed [SAMPLE_WIDTH-1:0]   s_axis_tdata;   // [23:0] sample_in
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic signed [SAMPLE_WIDTH-1:0]   m_axis_tdata;   // [23:0] sample_out
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [APB_ADDR_WIDTH-1:0]        paddr;
  logic [APB_DATA_WIDTH-1:0]        pwdata;
  logic [APB_DATA_WIDTH-1:0]        prdata;
  logic                             pready;

  // Filter state mirrored on the bench side.
  cfg_t                             coefs;
  logic signed [SAMPLE_WIDTH-1:0]   x_d1, x_d2, y_d1, y_d2;
  logic signed [SAMPLE_WIDTH-1:0]   filtered_q[$];
  stim_row_t                        directed_rows[$];

  logic signed [SAMPLE_WIDTH-1:0]   want_out;
  int                               mismatches = 0;
  int                               compared = 0;
  int                               words_sent = 0;
  int                               directed_words = 0;
  int                               settings = 0;
  int                               idle_run = 0;

  biquad_iir_filter_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] clip(input longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // Direct form I step: five products, round half up, saturate (this is the
  // fed-back value), then gain, round half up, saturate again.
  function automatic logic signed [SAMPLE_WIDTH-1:0] filter_step(
    input logic signed [SAMPLE_WIDTH-1:0] x
  );
    longint                         acc;
    longint                         scaled;
    logic signed [SAMPLE_WIDTH-1:0] y;
    acc = longint'($signed(coefs.ff0)) * longint'(x)
        + longint'($signed(coefs.ff1)) * longint'(x_d1)
        + longint'($signed(coefs.ff2)) * longint'(x_d2)
        - longint'($signed(coefs.fb1)) * longint'(y_d1)
        - longint'($signed(coefs.fb2)) * longint'(y_d2);
    y = clip((acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
    x_d2 = x_d1;
    x_d1 = x;
    y_d2 = y_d1;
    y_d1 = y;
    scaled = longint'(y) * longint'(coefs.gain);
    return clip((scaled + (longint'(1) << (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS);
  endfunction

  // Register shadow: coefficients keep 25 bits, gain 24, holes are ignored.
  function automatic void apply_reg(input logic [REG_IDX_WIDTH-1:0] idx,
                                    input logic [APB_DATA_WIDTH-1:0] data);
    case (idx)
      REG_FF0:  coefs.ff0  = data[COEF_WIDTH-1:0];
      REG_FF1:  coefs.ff1  = data[COEF_WIDTH-1:0];
      REG_FF2:  coefs.ff2  = data[COEF_WIDTH-1:0];
      REG_FB1:  coefs.fb1  = data[COEF_WIDTH-1:0];
      REG_FB2:  coefs.fb2  = data[COEF_WIDTH-1:0];
      REG_GAIN: coefs.gain = data[GAIN_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  // Setup, access (write lands at the next edge), then an idle step with psel low so that
  // back-to-back writes never assign psel twice in a step.
  task automatic apb_write(input logic [REG_IDX_WIDTH-1:0] idx,
                           input logic [APB_DATA_WIDTH-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  // Present one word and hold it until accepted; the expected output is
  // queued at the accepting edge.
  task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] x,
                           input bit has_want,
                           input logic signed [SAMPLE_WIDTH-1:0] want);
    logic signed [SAMPLE_WIDTH-1:0] predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    predicted = filter_step(x);
    filtered_q.push_back(has_want ? want : predicted);
    words_sent++;
  endtask

  // Sender goes quiet until every queued output has come back, then lets the
  // core settle. Register writes only happen after this.
  task automatic wait_outputs_done();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void add_write(input logic [REG_IDX_WIDTH-1:0] idx,
                                    input logic [APB_DATA_WIDTH-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.wdata   = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_sample(input logic signed [SAMPLE_WIDTH-1:0] x,
                                     input bit has_want,
                                     input logic signed [SAMPLE_WIDTH-1:0] want);
    stim_row_t r;
    r = '0;
    r.kind     = ROW_SAMPLE;
    r.sample   = x;
    r.has_want = has_want;
    r.want     = want;
    directed_rows.push_back(r);
  endfunction

  // Mostly full-range noise, with rails, tiny values and near-zero mixed in.
  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    int                             pick;
    logic signed [SAMPLE_WIDTH-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      v = $urandom_range(0, 1) ? S_MAX : S_MIN;
    end else if (pick == 1) begin
      v = SAMPLE_WIDTH'($urandom_range(0, 510));
      v = v - 24'sd255;
    end else if (pick == 2) begin
      v = SAMPLE_WIDTH'($urandom_range(0, 2));
      v = v - 24'sd1;
    end else begin
      v = SAMPLE_WIDTH'($urandom);
    end
    return v;
  endfunction

  // Pick a coefficient set for one phase and write all six registers, with
  // junk in the unused upper bits of every write word.
  task automatic new_setting(input int mode);
    cfg_t                      pick;
    logic [APB_DATA_WIDTH-1:0] word;
    logic [REG_IDX_WIDTH-1:0]  idx;
    pick.ff0  = COEF_WIDTH'($urandom);
    pick.ff1  = COEF_WIDTH'($urandom);
    pick.ff2  = COEF_WIDTH'($urandom);
    pick.fb1  = COEF_WIDTH'($urandom);
    pick.fb2  = COEF_WIDTH'($urandom);
    pick.gain = GAIN_WIDTH'($urandom);
    case (mode)
      0: begin                            // every coefficient and gain at top
        pick = '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, G_MAX};
      end
      1: begin                            // every coefficient at bottom
        pick.ff0 = C_MIN;
        pick.ff1 = C_MIN;
        pick.ff2 = C_MIN;
        pick.fb1 = C_MIN;
        pick.fb2 = C_MIN;
      end
      3: begin                            // tame filter, gain near unity
        pick.ff0  = COEF_WIDTH'($urandom_range(0, 1 << 22) - (1 << 21));
        pick.ff1  = COEF_WIDTH'($urandom_range(0, 1 << 22) - (1 << 21));
        pick.ff2  = COEF_WIDTH'($urandom_range(0, 1 << 22) - (1 << 21));
        pick.fb1  = COEF_WIDTH'($urandom_range(0, 1 << 23) - (1 << 22));
        pick.fb2  = COEF_WIDTH'($urandom_range(0, 1 << 21) - (1 << 20));
        pick.gain = GAIN_WIDTH'($urandom_range(1 << 19, 1 << 21));
      end
      4: begin                            // feedforward only
        pick.fb1 = '0;
        pick.fb2 = '0;
      end
      5: begin                            // mild feedback, full gain
        pick.fb1  = COEF_WIDTH'($urandom_range(0, 1 << 22) - (1 << 21));
        pick.fb2  = COEF_WIDTH'($urandom_range(0, 1 << 20) - (1 << 19));
        pick.gain = G_MAX;
      end
      default: ;                          // fully random
    endcase
    for (int i = 0; i <= int'(REG_GAIN); i++) begin
      idx  = REG_IDX_WIDTH'(i);
      word = $urandom;
      case (idx)
        REG_FF0:  word[COEF_WIDTH-1:0] = pick.ff0;
        REG_FF1:  word[COEF_WIDTH-1:0] = pick.ff1;
        REG_FF2:  word[COEF_WIDTH-1:0] = pick.ff2;
        REG_FB1:  word[COEF_WIDTH-1:0] = pick.fb1;
        REG_FB2:  word[COEF_WIDTH-1:0] = pick.fb2;
        default:  word[GAIN_WIDTH-1:0] = pick.gain;
      endcase
      apb_write(idx, word);
    end
    // now and then poke a hole in the map
    if ($urandom_range(0, 2) == 0) begin
      apb_write($urandom_range(0, 1) ? REG_HOLE6 : REG_HOLE7, $urandom);
    end
    settings++;
  endtask

  // Receiver: ready runs of random length broken by stalls, with the odd
  // long run of no stalls at all.
  initial begin
    int run_len;
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 30);
      m_axis_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                          : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Output checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        report($sformatf("output word %0d with nothing outstanding", m_axis_tdata));
      end else begin
        want_out = filtered_q.pop_front();
        compared++;
        if (m_axis_tdata !== want_out) begin
          report($sformatf("sample_out got %0d want %0d", m_axis_tdata, want_out));
        end
      end
    end
  end

  // Watchdog on stream activity.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int        left;
    int        burst;
    int        gap;
    stim_row_t row;

    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;

    coefs.ff0  = FF0_RESET;
    coefs.ff1  = '0;
    coefs.ff2  = '0;
    coefs.fb1  = '0;
    coefs.fb2  = '0;
    coefs.gain = GAIN_RESET;
    x_d1 = '0;
    x_d2 = '0;
    y_d1 = '0;
    y_d2 = '0;

    // Out of reset ff0 = 1.0 and gain = 1.0: the core passes samples through.
    add_sample(S_MAX, 1, S_MAX);
    add_sample(S_MIN, 1, S_MIN);
    add_sample(24'sd0, 1, 24'sd0);
    add_sample(24'sd1, 1, 24'sd1);
    add_sample(-24'sd1, 1, -24'sd1);
    // Upper bits beyond the register width are dropped: both still 1.0.
    add_write(REG_FF0, 32'hFE40_0000);
    add_write(REG_GAIN, 32'hFF10_0000);
    // Writes to unmapped offsets leave everything alone.
    add_write(REG_HOLE6, 32'hFFFF_FFFF);
    add_write(REG_HOLE7, 32'h1234_5678);
    add_sample(24'sd4660, 1, 24'sd4660);
    // Gain near 16x: rails clamp after scaling.
    add_write(REG_GAIN, {8'h00, G_MAX});
    add_sample(S_MAX, 1, S_MAX);
    add_sample(S_MIN, 1, S_MIN);
    add_sample(24'sd1, 0, '0);
    // Zero gain mutes the output.
    add_write(REG_GAIN, 32'h0000_0000);
    add_sample(S_MAX, 1, 24'sd0);
    add_sample(S_MIN, 1, 24'sd0);
    // ff0 near 4.0: the fed-back value itself saturates before the gain.
    add_write(REG_GAIN, 32'h0010_0000);
    add_write(REG_FF0, {7'h00, C_MAX});
    add_sample(S_MAX, 1, S_MAX);
    add_sample(S_MIN, 1, S_MIN);
    // Feedback and older taps at the extremes, checked by the predictor.
    add_write(REG_FB1, {7'h00, C_MIN});
    add_sample(24'sd0, 0, '0);
    add_sample(24'sd0, 0, '0);
    add_sample(S_MAX, 0, '0);
    add_write(REG_FF1, 32'hA500_0000);
    add_write(REG_FF2, {7'h00, C_MAX});
    add_write(REG_FB2, 32'h7EFF_FFFF);
    add_sample(S_MIN, 0, '0);
    add_sample(24'sd12345, 0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_outputs_done();
        apb_write(row.reg_idx, row.wdata);
      end else begin
        send_word(row.sample, row.has_want, row.want);
        directed_words++;
      end
    end

    // Random phases: new coefficients while idle, then bursty traffic. Each
    // phase boundary also holds the sender until the core has drained.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_outputs_done();
      new_setting(phase % 6);
      left = PHASE_WORDS;
      while (left > 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                            : $urandom_range(1, 24);
        for (int k = 0; k < burst && left > 0; k++) begin
          send_word(rand_sample(), 0, '0);
          left--;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0 && left > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    wait_outputs_done();

    $display("Sent %0d sample words (%0d directed) under %0d random coefficient sets;",
             words_sent, directed_words, settings);
    $display("compared %0d output words, %0d of them wrong.", compared, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
